// ===== rtl/lncc_pkg.sv =====
// Shared constants, types and register indexes of the local correlation block.
`default_nettype none

package lncc_pkg;

    localparam int MAX_WINDOW       = 16;
    localparam int MAX_PADDED_WIDTH = 2048;

    localparam int LOG_WIN   = $clog2(MAX_WINDOW);
    localparam int PIX_W     = 8;
    localparam int COL_W     = $clog2(MAX_PADDED_WIDTH);
    localparam int ROW_W     = COL_W + 1;
    localparam int HROW_W    = $clog2(MAX_WINDOW - 1);
    localparam int SLOT_W    = LOG_WIN;
    localparam int WS_W      = 5;
    localparam int HIST_DEPTH = (MAX_WINDOW - 1) * MAX_PADDED_WIDTH;
    localparam int HIST_AW   = HROW_W + COL_W;

    localparam int CLIN_W    = PIX_W + LOG_WIN;
    localparam int CSQ_W     = 2 * PIX_W + LOG_WIN;
    localparam int WLIN_W    = PIX_W + 2 * LOG_WIN;
    localparam int WSQ_W     = 2 * PIX_W + 2 * LOG_WIN;
    localparam int N_W       = 2 * LOG_WIN + 1;
    localparam int N2_W      = 4 * LOG_WIN + 1;
    localparam int A_W       = WSQ_W + 2 * LOG_WIN;
    localparam int R_W       = A_W + 16;

    localparam int RAD_W     = 64;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int DIV_STEPS = 17;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_REG_WEIGHT   = 2'd3;

    localparam logic [4:0]  RST_WINDOW_SIZE  = 5'd8;
    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [15:0] RST_REG_WEIGHT   = 16'd3277;

    // Vertical sums of one column: linear and product terms of both images.
    typedef struct packed {
        logic [CLIN_W-1:0] f;
        logic [CLIN_W-1:0] g;
        logic [CSQ_W-1:0]  ff;
        logic [CSQ_W-1:0]  gg;
        logic [CSQ_W-1:0]  fg;
    } vsum_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sq_status_t;

endpackage

`default_nettype wire

// ===== rtl/local_normalized_cross_correlation_top.sv =====
// Top level of the box-window normalized cross-correlation block.
//
// Usage: co-located pixel pairs of two images arrive on the s_ stream in raster
// order over a zero-padded frame (image_width + window_size - 1 columns by
// image_height + window_size - 1 rows). s_tuser marks the first pixel of a
// frame and restarts the raster there. For each window origin the block sends
// one transaction on the m_ stream carrying the signed Q2.14 correlation and
// the origin's row and column; m_tlast flags the last result of a frame.
// The user must write the configuration registers through the cfg_ channel
// only while the block is idle; the block itself does not enforce this.
// Window size and image dimensions take effect at the next frame. A pixel that
// closes a window holds off input until its result is loaded: the 32-step
// iterative square root and, unless the result is zero or saturates, the
// 17-step restoring divider follow the read-modify-write of the memories.
// Reset: counters and sums clear and the block waits at the origin of a fresh
// frame with the reset register values. No clearing pass is needed: column
// sums read as zero in the top row of every frame.
// If the receiver stalls, the finished result waits in the output register
// while the next pixel is already accepted; a second result waits until the
// first transaction completes.
`default_nettype none

module local_normalized_cross_correlation_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream: tdata = f_pixel[7:0], g_pixel[15:8]; tuser = frame_start.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tuser,
    // Output stream: tdata = corr_value[15:0], out_row[26:16], out_col[37:27],
    // zero fill[39:38]; tlast = frame_end.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,
    output logic             m_tlast,
    // Configuration writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_UPD, ST_MUL, ST_DIFF, ST_WGT, ST_SUM,
        ST_SQRT, ST_DMUL, ST_DCHK, ST_DIV, ST_FIN
    } state_t;

    typedef struct packed {
        logic top_row;
        logic hist_old;
        logic first_col;
        logic drop;
        logic emit;
        logic last;
    } item_flags_t;

    localparam int DCNT_W = $clog2(lncc_pkg::DIV_STEPS);

    // Configuration registers and frame-latched copies.
    logic [4:0]  cfg_ws_reg;
    logic [10:0] cfg_w_reg;
    logic [10:0] cfg_h_reg;
    logic [15:0] cfg_wt_reg;
    logic [4:0]  lat_ws_reg;
    logic [10:0] lat_w_reg;
    logic [10:0] lat_h_reg;

    // Raster position.
    logic [lncc_pkg::ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [lncc_pkg::COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [lncc_pkg::HROW_W-1:0] hrow_reg, hrow_next;
    logic [lncc_pkg::SLOT_W-1:0] slot_reg, slot_next;

    state_t state_reg, state_next;
    logic   accept;

    // Accept-cycle decode.
    logic [lncc_pkg::ROW_W-1:0]  pr_cur;
    logic [lncc_pkg::COL_W-1:0]  pc_cur;
    logic [lncc_pkg::HROW_W-1:0] hrow_cur;
    logic [lncc_pkg::SLOT_W-1:0] slot_cur;
    logic                        at_origin;
    logic [4:0]                  ws_c, ws_e;
    logic [11:0]                 w_lim;
    logic [10:0]                 w_c, h_c, w_e, h_e;
    logic [11:0]                 pw, ph;
    logic                        in_frame;
    logic                        row_wrap;
    item_flags_t                 flags_cur;

    // Item held for the update step.
    logic [7:0]                  it_f, it_g;
    logic [lncc_pkg::COL_W-1:0]  it_pc;
    logic [lncc_pkg::HROW_W-1:0] it_hrow;
    logic [lncc_pkg::SLOT_W-1:0] it_slot;
    logic [4:0]                  it_ws;
    logic [lncc_pkg::N_W-1:0]    it_n;
    item_flags_t                 it_flags;
    logic [10:0]                 it_orow, it_ocol;

    // Memories.
    logic [15:0]          hist_mem [lncc_pkg::HIST_DEPTH];
    lncc_pkg::vsum_t      col_mem  [lncc_pkg::MAX_PADDED_WIDTH];
    logic [15:0]          hist_rd_reg;
    lncc_pkg::vsum_t      col_rd_reg;
    lncc_pkg::vsum_t      ring_reg [lncc_pkg::MAX_WINDOW];
    logic                 mem_wr;

    // Window sums.
    logic [lncc_pkg::WLIN_W-1:0] wsum_f_reg, wsum_g_reg, wsum_f_next, wsum_g_next;
    logic [lncc_pkg::WSQ_W-1:0]  wsum_ff_reg, wsum_gg_reg, wsum_fg_reg;
    logic [lncc_pkg::WSQ_W-1:0]  wsum_ff_next, wsum_gg_next, wsum_fg_next;

    // Update-step values.
    lncc_pkg::vsum_t nv, old, col_base, vert, col_wr, drop;
    logic [15:0]     nv_ff, nv_gg, nv_fg, od_ff, od_gg, od_fg;

    // Correlation datapath.
    logic [lncc_pkg::A_W-1:0]  p_nff_reg, p_ngg_reg, p_nfg_reg;
    logic [lncc_pkg::A_W-1:0]  p_sff_reg, p_sgg_reg, p_sfg_reg;
    logic [lncc_pkg::N2_W-1:0] n2_reg;
    logic [lncc_pkg::A_W:0]    af, ag, cc;
    logic [lncc_pkg::A_W-1:0]  a_f_reg, a_g_reg;
    logic [lncc_pkg::A_W:0]    m_reg;
    logic                      neg_reg;
    logic [16:0]               wc_reg;
    logic [lncc_pkg::R_W:0]    pa_f_reg, pa_g_reg;
    logic [32:0]               pb_reg;
    logic [lncc_pkg::R_W-1:0]  r_f, r_g;
    logic [lncc_pkg::RAD_W-1:0] rad_f, rad_g;
    logic                      sq_start;
    lncc_pkg::sq_status_t      sq_f_status, sq_g_status;
    logic [lncc_pkg::ROOT_W-1:0] root_f, root_g;
    logic [63:0]               d_reg;
    logic [63:0]               m_shift;
    logic [63:0]               rem_reg;
    logic [64:0]               rem_sh;
    logic                      div_ge;
    logic [16:0]               q_reg;
    logic [DCNT_W-1:0]         div_cnt_reg;
    logic                      sat_reg, zero_reg;

    // Output stage.
    logic        out_valid_reg;
    logic [15:0] out_corr_reg;
    logic [10:0] out_row_reg, out_col_reg;
    logic        out_last_reg;
    logic [17:0] q_round;
    logic        over;
    logic [15:0] corr_res;
    logic        out_load;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ws_reg <= lncc_pkg::RST_WINDOW_SIZE;
            cfg_w_reg  <= lncc_pkg::RST_IMAGE_WIDTH;
            cfg_h_reg  <= lncc_pkg::RST_IMAGE_HEIGHT;
            cfg_wt_reg <= lncc_pkg::RST_REG_WEIGHT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lncc_pkg::CFG_WINDOW_SIZE:  cfg_ws_reg <= cfg_data[4:0];
                lncc_pkg::CFG_IMAGE_WIDTH:  cfg_w_reg  <= cfg_data[10:0];
                lncc_pkg::CFG_IMAGE_HEIGHT: cfg_h_reg  <= cfg_data[10:0];
                lncc_pkg::CFG_REG_WEIGHT:   cfg_wt_reg <= cfg_data;
                default:                    cfg_wt_reg <= cfg_wt_reg;
            endcase
        end
    end

    // Position of the arriving pixel, frame geometry and derived flags.
    always_comb
    begin
        pr_cur    = s_tuser ? '0 : row_cnt_reg;
        pc_cur    = s_tuser ? '0 : col_cnt_reg;
        hrow_cur  = s_tuser ? '0 : hrow_reg;
        slot_cur  = s_tuser ? '0 : slot_reg;
        at_origin = (pr_cur == '0) && (pc_cur == '0);

        if (cfg_ws_reg == 5'd0)
            ws_c = 5'd1;
        else if (cfg_ws_reg > 5'(lncc_pkg::MAX_WINDOW))
            ws_c = 5'(lncc_pkg::MAX_WINDOW);
        else
            ws_c = cfg_ws_reg;
        w_lim = 12'(lncc_pkg::MAX_PADDED_WIDTH + 1) - 12'(ws_c);
        if (cfg_w_reg == 11'd0)
            w_c = 11'd1;
        else if (12'(cfg_w_reg) > w_lim)
            w_c = w_lim[10:0];
        else
            w_c = cfg_w_reg;
        h_c = (cfg_h_reg == 11'd0) ? 11'd1 : cfg_h_reg;

        ws_e = at_origin ? ws_c : lat_ws_reg;
        w_e  = at_origin ? w_c  : lat_w_reg;
        h_e  = at_origin ? h_c  : lat_h_reg;
        pw   = 12'(w_e) + 12'(ws_e) - 12'd1;
        ph   = 12'(h_e) + 12'(ws_e) - 12'd1;
        in_frame = (pr_cur < ph) && (12'(pc_cur) < pw);
        row_wrap = (12'(pc_cur) + 12'd1 >= pw);

        flags_cur.top_row   = (pr_cur == '0);
        flags_cur.hist_old  = (pr_cur >= 12'(ws_e) - 12'd1);
        flags_cur.first_col = (pc_cur == '0);
        flags_cur.drop      = (12'(pc_cur) >= 12'(ws_e));
        flags_cur.emit      = flags_cur.hist_old && (12'(pc_cur) >= 12'(ws_e) - 12'd1);
        flags_cur.last      = (pr_cur == ph - 12'd1) && (12'(pc_cur) == pw - 12'd1);

        row_cnt_next = pr_cur;
        col_cnt_next = pc_cur;
        hrow_next    = hrow_cur;
        slot_next    = slot_cur;
        if (in_frame)
        begin
            if (row_wrap)
            begin
                col_cnt_next = '0;
                row_cnt_next = pr_cur + 1'b1;
                slot_next    = '0;
                if ((ws_e <= 5'd2) || (5'(hrow_cur) == ws_e - 5'd2))
                    hrow_next = '0;
                else
                    hrow_next = hrow_cur + 1'b1;
            end
            else
            begin
                col_cnt_next = pc_cur + 1'b1;
                if (5'(slot_cur) == ws_e - 5'd1)
                    slot_next = '0;
                else
                    slot_next = slot_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            hrow_reg    <= '0;
            slot_reg    <= '0;
            lat_ws_reg  <= lncc_pkg::RST_WINDOW_SIZE;
            lat_w_reg   <= lncc_pkg::RST_IMAGE_WIDTH;
            lat_h_reg   <= lncc_pkg::RST_IMAGE_HEIGHT;
        end
        else if (accept)
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            hrow_reg    <= hrow_next;
            slot_reg    <= slot_next;
            lat_ws_reg  <= ws_e;
            lat_w_reg   <= w_e;
            lat_h_reg   <= h_e;
        end
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            it_f     <= s_tdata[7:0];
            it_g     <= s_tdata[15:8];
            it_pc    <= pc_cur;
            it_hrow  <= hrow_cur;
            it_slot  <= slot_cur;
            it_ws    <= ws_e;
            it_n     <= lncc_pkg::N_W'(10'(ws_e) * 10'(ws_e));
            it_flags <= flags_cur;
            it_orow  <= 11'(pr_cur - (12'(ws_e) - 12'd1));
            it_ocol  <= 11'(12'(pc_cur) - (12'(ws_e) - 12'd1));
        end
    end

    // Line history and column sums: read on accept, written back in the update step when the window is wider than one.
    assign mem_wr = (state_reg == ST_UPD) && (it_ws != 5'd1);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_rd_reg <= hist_mem[{hrow_cur, pc_cur}];
            col_rd_reg  <= col_mem[pc_cur];
        end
        if (mem_wr)
        begin
            hist_mem[{it_hrow, it_pc}] <= {it_g, it_f};
            col_mem[it_pc]             <= col_wr;
        end
    end

    // Update step: vertical sums, column write-back, running window sums.
    always_comb
    begin
        nv_ff = it_f * it_f;
        nv_gg = it_g * it_g;
        nv_fg = it_f * it_g;
        od_ff = hist_rd_reg[7:0] * hist_rd_reg[7:0];
        od_gg = hist_rd_reg[15:8] * hist_rd_reg[15:8];
        od_fg = hist_rd_reg[7:0] * hist_rd_reg[15:8];

        nv.f  = lncc_pkg::CLIN_W'(it_f);
        nv.g  = lncc_pkg::CLIN_W'(it_g);
        nv.ff = lncc_pkg::CSQ_W'(nv_ff);
        nv.gg = lncc_pkg::CSQ_W'(nv_gg);
        nv.fg = lncc_pkg::CSQ_W'(nv_fg);

        if (it_flags.hist_old)
        begin
            old.f  = lncc_pkg::CLIN_W'(hist_rd_reg[7:0]);
            old.g  = lncc_pkg::CLIN_W'(hist_rd_reg[15:8]);
            old.ff = lncc_pkg::CSQ_W'(od_ff);
            old.gg = lncc_pkg::CSQ_W'(od_gg);
            old.fg = lncc_pkg::CSQ_W'(od_fg);
        end
        else
            old = '0;

        col_base = it_flags.top_row ? '0 : col_rd_reg;
        if (it_ws == 5'd1)
            vert = nv;
        else
        begin
            vert.f  = col_base.f  + nv.f;
            vert.g  = col_base.g  + nv.g;
            vert.ff = col_base.ff + nv.ff;
            vert.gg = col_base.gg + nv.gg;
            vert.fg = col_base.fg + nv.fg;
        end
        col_wr.f  = vert.f  - old.f;
        col_wr.g  = vert.g  - old.g;
        col_wr.ff = vert.ff - old.ff;
        col_wr.gg = vert.gg - old.gg;
        col_wr.fg = vert.fg - old.fg;

        drop = it_flags.drop ? ring_reg[it_slot] : '0;

        wsum_f_next  = (it_flags.first_col ? '0 : wsum_f_reg)
                     + lncc_pkg::WLIN_W'(vert.f) - lncc_pkg::WLIN_W'(drop.f);
        wsum_g_next  = (it_flags.first_col ? '0 : wsum_g_reg)
                     + lncc_pkg::WLIN_W'(vert.g) - lncc_pkg::WLIN_W'(drop.g);
        wsum_ff_next = (it_flags.first_col ? '0 : wsum_ff_reg)
                     + lncc_pkg::WSQ_W'(vert.ff) - lncc_pkg::WSQ_W'(drop.ff);
        wsum_gg_next = (it_flags.first_col ? '0 : wsum_gg_reg)
                     + lncc_pkg::WSQ_W'(vert.gg) - lncc_pkg::WSQ_W'(drop.gg);
        wsum_fg_next = (it_flags.first_col ? '0 : wsum_fg_reg)
                     + lncc_pkg::WSQ_W'(vert.fg) - lncc_pkg::WSQ_W'(drop.fg);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPD)
            ring_reg[it_slot] <= vert;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsum_f_reg  <= '0;
            wsum_g_reg  <= '0;
            wsum_ff_reg <= '0;
            wsum_gg_reg <= '0;
            wsum_fg_reg <= '0;
        end
        else if (state_reg == ST_UPD)
        begin
            wsum_f_reg  <= wsum_f_next;
            wsum_g_reg  <= wsum_g_next;
            wsum_ff_reg <= wsum_ff_next;
            wsum_gg_reg <= wsum_gg_next;
            wsum_fg_reg <= wsum_fg_next;
        end
    end

    // Correlation arithmetic: scaled variances and covariance, regularization,
    // roots, then a restoring division with a rounding bit.
    always_comb
    begin
        af = (lncc_pkg::A_W + 1)'(p_nff_reg) - (lncc_pkg::A_W + 1)'(p_sff_reg);
        ag = (lncc_pkg::A_W + 1)'(p_ngg_reg) - (lncc_pkg::A_W + 1)'(p_sgg_reg);
        cc = (lncc_pkg::A_W + 1)'(p_nfg_reg) - (lncc_pkg::A_W + 1)'(p_sfg_reg);
        r_f = lncc_pkg::R_W'(pa_f_reg + (lncc_pkg::R_W + 1)'(pb_reg));
        r_g = lncc_pkg::R_W'(pa_g_reg + (lncc_pkg::R_W + 1)'(pb_reg));
        rad_f = lncc_pkg::RAD_W'({r_f, 14'b0});
        rad_g = lncc_pkg::RAD_W'({r_g, 14'b0});
        m_shift = 64'({m_reg, 28'b0});
        rem_sh  = {rem_reg, 1'b0};
        div_ge  = (rem_sh >= {1'b0, d_reg});
    end

    assign sq_start = (state_reg == ST_SUM);

    lncc_sqrt u_sqrt_f (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (rad_f),
        .status   (sq_f_status),
        .root     (root_f)
    );

    lncc_sqrt u_sqrt_g (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (rad_g),
        .status   (sq_g_status),
        .root     (root_g)
    );

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_MUL:
            begin
                p_nff_reg <= lncc_pkg::A_W'(it_n) * lncc_pkg::A_W'(wsum_ff_reg);
                p_ngg_reg <= lncc_pkg::A_W'(it_n) * lncc_pkg::A_W'(wsum_gg_reg);
                p_nfg_reg <= lncc_pkg::A_W'(it_n) * lncc_pkg::A_W'(wsum_fg_reg);
                p_sff_reg <= lncc_pkg::A_W'(wsum_f_reg) * lncc_pkg::A_W'(wsum_f_reg);
                p_sgg_reg <= lncc_pkg::A_W'(wsum_g_reg) * lncc_pkg::A_W'(wsum_g_reg);
                p_sfg_reg <= lncc_pkg::A_W'(wsum_f_reg) * lncc_pkg::A_W'(wsum_g_reg);
                n2_reg    <= lncc_pkg::N2_W'(it_n) * lncc_pkg::N2_W'(it_n);
            end
            ST_DIFF:
            begin
                a_f_reg <= af[lncc_pkg::A_W] ? '0 : af[lncc_pkg::A_W-1:0];
                a_g_reg <= ag[lncc_pkg::A_W] ? '0 : ag[lncc_pkg::A_W-1:0];
                neg_reg <= cc[lncc_pkg::A_W];
                m_reg   <= cc[lncc_pkg::A_W] ? ((lncc_pkg::A_W + 1)'(0) - cc) : cc;
                wc_reg  <= 17'h10000 - 17'(cfg_wt_reg);
            end
            ST_WGT:
            begin
                pa_f_reg <= (lncc_pkg::R_W + 1)'(a_f_reg) * (lncc_pkg::R_W + 1)'(wc_reg);
                pa_g_reg <= (lncc_pkg::R_W + 1)'(a_g_reg) * (lncc_pkg::R_W + 1)'(wc_reg);
                pb_reg   <= 33'(cfg_wt_reg) * 33'(n2_reg);
            end
            ST_DMUL:
            begin
                d_reg <= 64'(root_f) * 64'(root_g);
            end
            ST_DCHK:
            begin
                zero_reg    <= (d_reg == 64'd0);
                sat_reg     <= (m_shift >= d_reg);
                rem_reg     <= m_shift;
                q_reg       <= '0;
                div_cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg     <= div_ge ? 64'(rem_sh - {1'b0, d_reg}) : rem_sh[63:0];
                q_reg       <= {q_reg[15:0], div_ge};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            default:
            begin
                d_reg <= d_reg;
            end
        endcase
    end

    // Rounding of the quotient, saturation to Q2.14, and a zero result for a zero denominator.
    always_comb
    begin
        q_round = (18'(q_reg) + 18'd1) >> 1;
        over    = sat_reg || q_round[17] || q_round[16];
        if (zero_reg)
            corr_res = 16'h0000;
        else if (!neg_reg)
            corr_res = (over || (q_round > 18'd32767)) ? 16'h7FFF : q_round[15:0];
        else
            corr_res = (over || (q_round > 18'd32768)) ? 16'h8000
                                                       : 16'(18'd0 - q_round);
        out_load = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && in_frame) state_next = ST_UPD;
            ST_UPD:  state_next = it_flags.emit ? ST_MUL : ST_IDLE;
            ST_MUL:  state_next = ST_DIFF;
            ST_DIFF: state_next = ST_WGT;
            ST_WGT:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_SQRT;
            ST_SQRT: if (sq_f_status.done) state_next = ST_DMUL;
            ST_DMUL: state_next = ST_DCHK;
            ST_DCHK:
            begin
                if ((d_reg == 64'd0) || (m_shift >= d_reg))
                    state_next = ST_FIN;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DCNT_W'(lncc_pkg::DIV_STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_corr_reg  <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_corr_reg  <= corr_res;
                out_row_reg   <= it_orow;
                out_col_reg   <= it_ocol;
                out_last_reg  <= it_flags.last;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_col_reg, out_row_reg, out_corr_reg};
    assign m_tlast  = out_last_reg;

    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_frame) |=> (state_reg == ST_UPD))
        else $error("accepted pixel inside the frame did not enter the update step");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result appeared without a finished correlation");

    a_roots_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_f_status.done == sq_g_status.done) && (sq_f_status.busy == sq_g_status.busy))
        else $error("square root units out of step");

    a_sqrt_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> (sq_f_status.busy || sq_f_status.done))
        else $error("waiting on a square root that is not running");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_cnt_reg < DCNT_W'(lncc_pkg::DIV_STEPS)))
        else $error("divider step count out of range");

endmodule

`default_nettype wire

// ===== rtl/lncc_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none

module lncc_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [lncc_pkg::RAD_W-1:0]  radicand,
    output lncc_pkg::sq_status_t             status,
    output logic [lncc_pkg::ROOT_W-1:0]      root
);

    localparam int CNT_W = $clog2(lncc_pkg::ROOT_W);
    localparam int REM_W = lncc_pkg::ROOT_W + 2;

    logic [lncc_pkg::RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [lncc_pkg::ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [REM_W+1:0]            rem_sh;
    logic [REM_W+1:0]            trial;
    logic                        take;
    logic [REM_W-1:0]            rem_next;
    logic [lncc_pkg::ROOT_W-1:0] root_next;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[lncc_pkg::RAD_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        take      = (rem_sh >= trial);
        rem_next  = take ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
        root_next = {root_reg[lncc_pkg::ROOT_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(lncc_pkg::ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[lncc_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;

endmodule

`default_nettype wire
